### rtl/core/upc_pkg.sv
// Package for the Unicode printable classifier: word types shared by the cells
// and the constant table of non-printable code point ranges. No dependencies.
`timescale 1ns / 1ps

package upc_pkg;

    localparam int CP_W        = 21;
    localparam int ROM_ENTRIES = 548;

    typedef logic [CP_W-1:0] t_cp;

    // One inclusive range of non-printable code points
    typedef struct packed {
        t_cp first;
        t_cp last;
    } t_range;

    // Word handed from cell to cell along the chain
    typedef struct packed {
        logic valid;
        t_cp  code_point;
        logic hit;
    } t_cell_word;

    // Sorted, disjoint ranges of non-printable code points
    localparam t_range NP_ROM [ROM_ENTRIES] = '{
        '{21'h00000, 21'h0001F}, '{21'h0007F, 21'h0009F}, '{21'h0034F, 21'h0034F},
        '{21'h00378, 21'h00379}, '{21'h0037F, 21'h00383}, '{21'h0038B, 21'h0038B},
        '{21'h0038D, 21'h0038D}, '{21'h003A2, 21'h003A2}, '{21'h00528, 21'h00530},
        '{21'h00557, 21'h00558}, '{21'h00560, 21'h00560}, '{21'h00588, 21'h00588},
        '{21'h0058B, 21'h0058E}, '{21'h00590, 21'h00590}, '{21'h005C8, 21'h005CF},
        '{21'h005EB, 21'h005EF}, '{21'h005F5, 21'h00605}, '{21'h0061C, 21'h0061D},
        '{21'h006DD, 21'h006DD}, '{21'h0070E, 21'h0070F}, '{21'h0074B, 21'h0074C},
        '{21'h007B2, 21'h007BF}, '{21'h007FB, 21'h007FF}, '{21'h0082E, 21'h0082F},
        '{21'h0083F, 21'h0083F}, '{21'h0085C, 21'h0085D}, '{21'h0085F, 21'h0089F},
        '{21'h008A1, 21'h008A1}, '{21'h008AD, 21'h008E3}, '{21'h008FF, 21'h008FF},
        '{21'h00978, 21'h00978}, '{21'h00980, 21'h00980}, '{21'h00984, 21'h00984},
        '{21'h0098D, 21'h0098E}, '{21'h00991, 21'h00992}, '{21'h009A9, 21'h009A9},
        '{21'h009B1, 21'h009B1}, '{21'h009B3, 21'h009B5}, '{21'h009BA, 21'h009BB},
        '{21'h009C5, 21'h009C6}, '{21'h009C9, 21'h009CA}, '{21'h009CF, 21'h009D6},
        '{21'h009D8, 21'h009DB}, '{21'h009DE, 21'h009DE}, '{21'h009E4, 21'h009E5},
        '{21'h009FC, 21'h00A00}, '{21'h00A04, 21'h00A04}, '{21'h00A0B, 21'h00A0E},
        '{21'h00A11, 21'h00A12}, '{21'h00A29, 21'h00A29}, '{21'h00A31, 21'h00A31},
        '{21'h00A34, 21'h00A34}, '{21'h00A37, 21'h00A37}, '{21'h00A3A, 21'h00A3B},
        '{21'h00A3D, 21'h00A3D}, '{21'h00A43, 21'h00A46}, '{21'h00A49, 21'h00A4A},
        '{21'h00A4E, 21'h00A50}, '{21'h00A52, 21'h00A58}, '{21'h00A5D, 21'h00A5D},
        '{21'h00A5F, 21'h00A65}, '{21'h00A76, 21'h00A80}, '{21'h00A84, 21'h00A84},
        '{21'h00A8E, 21'h00A8E}, '{21'h00A92, 21'h00A92}, '{21'h00AA9, 21'h00AA9},
        '{21'h00AB1, 21'h00AB1}, '{21'h00AB4, 21'h00AB4}, '{21'h00ABA, 21'h00ABB},
        '{21'h00AC6, 21'h00AC6}, '{21'h00ACA, 21'h00ACA}, '{21'h00ACE, 21'h00ACF},
        '{21'h00AD1, 21'h00ADF}, '{21'h00AE4, 21'h00AE5}, '{21'h00AF2, 21'h00B00},
        '{21'h00B04, 21'h00B04}, '{21'h00B0D, 21'h00B0E}, '{21'h00B11, 21'h00B12},
        '{21'h00B29, 21'h00B29}, '{21'h00B31, 21'h00B31}, '{21'h00B34, 21'h00B34},
        '{21'h00B3A, 21'h00B3B}, '{21'h00B45, 21'h00B46}, '{21'h00B49, 21'h00B4A},
        '{21'h00B4E, 21'h00B55}, '{21'h00B58, 21'h00B5B}, '{21'h00B5E, 21'h00B5E},
        '{21'h00B64, 21'h00B65}, '{21'h00B78, 21'h00B81}, '{21'h00B84, 21'h00B84},
        '{21'h00B8B, 21'h00B8D}, '{21'h00B91, 21'h00B91}, '{21'h00B96, 21'h00B98},
        '{21'h00B9B, 21'h00B9B}, '{21'h00B9D, 21'h00B9D}, '{21'h00BA0, 21'h00BA2},
        '{21'h00BA5, 21'h00BA7}, '{21'h00BAB, 21'h00BAD}, '{21'h00BBA, 21'h00BBD},
        '{21'h00BC3, 21'h00BC5}, '{21'h00BC9, 21'h00BC9}, '{21'h00BCE, 21'h00BCF},
        '{21'h00BD1, 21'h00BD6}, '{21'h00BD8, 21'h00BE5}, '{21'h00BFB, 21'h00C00},
        '{21'h00C04, 21'h00C04}, '{21'h00C0D, 21'h00C0D}, '{21'h00C11, 21'h00C11},
        '{21'h00C29, 21'h00C29}, '{21'h00C34, 21'h00C34}, '{21'h00C3A, 21'h00C3C},
        '{21'h00C45, 21'h00C45}, '{21'h00C49, 21'h00C49}, '{21'h00C4E, 21'h00C54},
        '{21'h00C57, 21'h00C57}, '{21'h00C5A, 21'h00C5F}, '{21'h00C64, 21'h00C65},
        '{21'h00C70, 21'h00C77}, '{21'h00C80, 21'h00C81}, '{21'h00C84, 21'h00C84},
        '{21'h00C8D, 21'h00C8D}, '{21'h00C91, 21'h00C91}, '{21'h00CA9, 21'h00CA9},
        '{21'h00CB4, 21'h00CB4}, '{21'h00CBA, 21'h00CBB}, '{21'h00CC5, 21'h00CC5},
        '{21'h00CC9, 21'h00CC9}, '{21'h00CCE, 21'h00CD4}, '{21'h00CD7, 21'h00CDD},
        '{21'h00CDF, 21'h00CDF}, '{21'h00CE4, 21'h00CE5}, '{21'h00CF0, 21'h00CF0},
        '{21'h00CF3, 21'h00D01}, '{21'h00D04, 21'h00D04}, '{21'h00D0D, 21'h00D0D},
        '{21'h00D11, 21'h00D11}, '{21'h00D3B, 21'h00D3C}, '{21'h00D45, 21'h00D45},
        '{21'h00D49, 21'h00D49}, '{21'h00D4F, 21'h00D56}, '{21'h00D58, 21'h00D5F},
        '{21'h00D64, 21'h00D65}, '{21'h00D76, 21'h00D78}, '{21'h00D80, 21'h00D81},
        '{21'h00D84, 21'h00D84}, '{21'h00D97, 21'h00D99}, '{21'h00DB2, 21'h00DB2},
        '{21'h00DBC, 21'h00DBC}, '{21'h00DBE, 21'h00DBF}, '{21'h00DC7, 21'h00DC9},
        '{21'h00DCB, 21'h00DCE}, '{21'h00DD5, 21'h00DD5}, '{21'h00DD7, 21'h00DD7},
        '{21'h00DE0, 21'h00DF1}, '{21'h00DF5, 21'h00E00}, '{21'h00E3B, 21'h00E3E},
        '{21'h00E5C, 21'h00E80}, '{21'h00E83, 21'h00E83}, '{21'h00E85, 21'h00E86},
        '{21'h00E89, 21'h00E89}, '{21'h00E8B, 21'h00E8C}, '{21'h00E8E, 21'h00E93},
        '{21'h00E98, 21'h00E98}, '{21'h00EA0, 21'h00EA0}, '{21'h00EA4, 21'h00EA4},
        '{21'h00EA6, 21'h00EA6}, '{21'h00EA8, 21'h00EA9}, '{21'h00EAC, 21'h00EAC},
        '{21'h00EBA, 21'h00EBA}, '{21'h00EBE, 21'h00EBF}, '{21'h00EC5, 21'h00EC5},
        '{21'h00EC7, 21'h00EC7}, '{21'h00ECE, 21'h00ECF}, '{21'h00EDA, 21'h00EDB},
        '{21'h00EE0, 21'h00EFF}, '{21'h00F48, 21'h00F48}, '{21'h00F6D, 21'h00F70},
        '{21'h00F98, 21'h00F98}, '{21'h00FBD, 21'h00FBD}, '{21'h00FCD, 21'h00FCD},
        '{21'h00FDB, 21'h00FFF}, '{21'h010C6, 21'h010C6}, '{21'h010C8, 21'h010CC},
        '{21'h010CE, 21'h010CF}, '{21'h0115F, 21'h01160}, '{21'h01249, 21'h01249},
        '{21'h0124E, 21'h0124F}, '{21'h01257, 21'h01257}, '{21'h01259, 21'h01259},
        '{21'h0125E, 21'h0125F}, '{21'h01289, 21'h01289}, '{21'h0128E, 21'h0128F},
        '{21'h012B1, 21'h012B1}, '{21'h012B6, 21'h012B7}, '{21'h012BF, 21'h012BF},
        '{21'h012C1, 21'h012C1}, '{21'h012C6, 21'h012C7}, '{21'h012D7, 21'h012D7},
        '{21'h01311, 21'h01311}, '{21'h01316, 21'h01317}, '{21'h0135B, 21'h0135C},
        '{21'h0137D, 21'h0137F}, '{21'h0139A, 21'h0139F}, '{21'h013F5, 21'h013FF},
        '{21'h0169D, 21'h0169F}, '{21'h016F1, 21'h016FF}, '{21'h0170D, 21'h0170D},
        '{21'h01715, 21'h0171F}, '{21'h01737, 21'h0173F}, '{21'h01754, 21'h0175F},
        '{21'h0176D, 21'h0176D}, '{21'h01771, 21'h01771}, '{21'h01774, 21'h0177F},
        '{21'h017B4, 21'h017B5}, '{21'h017DE, 21'h017DF}, '{21'h017EA, 21'h017EF},
        '{21'h017FA, 21'h017FF}, '{21'h0180B, 21'h0180D}, '{21'h0180F, 21'h0180F},
        '{21'h0181A, 21'h0181F}, '{21'h01878, 21'h0187F}, '{21'h018AB, 21'h018AF},
        '{21'h018F6, 21'h018FF}, '{21'h0191D, 21'h0191F}, '{21'h0192C, 21'h0192F},
        '{21'h0193C, 21'h0193F}, '{21'h01941, 21'h01943}, '{21'h0196E, 21'h0196F},
        '{21'h01975, 21'h0197F}, '{21'h019AC, 21'h019AF}, '{21'h019CA, 21'h019CF},
        '{21'h019DB, 21'h019DD}, '{21'h01A1C, 21'h01A1D}, '{21'h01A5F, 21'h01A5F},
        '{21'h01A7D, 21'h01A7E}, '{21'h01A8A, 21'h01A8F}, '{21'h01A9A, 21'h01A9F},
        '{21'h01AAE, 21'h01AFF}, '{21'h01B4C, 21'h01B4F}, '{21'h01B7D, 21'h01B7F},
        '{21'h01BF4, 21'h01BFB}, '{21'h01C38, 21'h01C3A}, '{21'h01C4A, 21'h01C4C},
        '{21'h01C80, 21'h01CBF}, '{21'h01CC8, 21'h01CCF}, '{21'h01CF7, 21'h01CFF},
        '{21'h01DE7, 21'h01DFB}, '{21'h01F16, 21'h01F17}, '{21'h01F1E, 21'h01F1F},
        '{21'h01F46, 21'h01F47}, '{21'h01F4E, 21'h01F4F}, '{21'h01F58, 21'h01F58},
        '{21'h01F5A, 21'h01F5A}, '{21'h01F5C, 21'h01F5C}, '{21'h01F5E, 21'h01F5E},
        '{21'h01F7E, 21'h01F7F}, '{21'h01FB5, 21'h01FB5}, '{21'h01FC5, 21'h01FC5},
        '{21'h01FD4, 21'h01FD5}, '{21'h01FDC, 21'h01FDC}, '{21'h01FF0, 21'h01FF1},
        '{21'h01FF5, 21'h01FF5}, '{21'h01FFF, 21'h01FFF}, '{21'h0200B, 21'h0200F},
        '{21'h0202A, 21'h0202E}, '{21'h02060, 21'h0206F}, '{21'h02072, 21'h02073},
        '{21'h0208F, 21'h0208F}, '{21'h0209D, 21'h0209F}, '{21'h020BB, 21'h020CF},
        '{21'h020F1, 21'h020FF}, '{21'h0218A, 21'h0218F}, '{21'h023F4, 21'h023FF},
        '{21'h02427, 21'h0243F}, '{21'h0244B, 21'h0245F}, '{21'h02700, 21'h02700},
        '{21'h02B4D, 21'h02B4F}, '{21'h02B5A, 21'h02BFF}, '{21'h02C2F, 21'h02C2F},
        '{21'h02C5F, 21'h02C5F}, '{21'h02CF4, 21'h02CF8}, '{21'h02D26, 21'h02D26},
        '{21'h02D28, 21'h02D2C}, '{21'h02D2E, 21'h02D2F}, '{21'h02D68, 21'h02D6E},
        '{21'h02D71, 21'h02D7E}, '{21'h02D97, 21'h02D9F}, '{21'h02DA7, 21'h02DA7},
        '{21'h02DAF, 21'h02DAF}, '{21'h02DB7, 21'h02DB7}, '{21'h02DBF, 21'h02DBF},
        '{21'h02DC7, 21'h02DC7}, '{21'h02DCF, 21'h02DCF}, '{21'h02DD7, 21'h02DD7},
        '{21'h02DDF, 21'h02DDF}, '{21'h02E3C, 21'h02E7F}, '{21'h02E9A, 21'h02E9A},
        '{21'h02EF4, 21'h02EFF}, '{21'h02FD6, 21'h02FEF}, '{21'h02FFC, 21'h02FFF},
        '{21'h03040, 21'h03040}, '{21'h03097, 21'h03098}, '{21'h03100, 21'h03104},
        '{21'h0312E, 21'h03130}, '{21'h03164, 21'h03164}, '{21'h0318F, 21'h0318F},
        '{21'h031BB, 21'h031BF}, '{21'h031E4, 21'h031EF}, '{21'h0321F, 21'h0321F},
        '{21'h032FF, 21'h032FF}, '{21'h04DB6, 21'h04DBF}, '{21'h09FCD, 21'h09FFF},
        '{21'h0A48D, 21'h0A48F}, '{21'h0A4C7, 21'h0A4CF}, '{21'h0A62C, 21'h0A63F},
        '{21'h0A698, 21'h0A69E}, '{21'h0A6F8, 21'h0A6FF}, '{21'h0A78F, 21'h0A78F},
        '{21'h0A794, 21'h0A79F}, '{21'h0A7AB, 21'h0A7F7}, '{21'h0A82C, 21'h0A82F},
        '{21'h0A83A, 21'h0A83F}, '{21'h0A878, 21'h0A87F}, '{21'h0A8C5, 21'h0A8CD},
        '{21'h0A8DA, 21'h0A8DF}, '{21'h0A8FC, 21'h0A8FF}, '{21'h0A954, 21'h0A95E},
        '{21'h0A97D, 21'h0A97F}, '{21'h0A9CE, 21'h0A9CE}, '{21'h0A9DA, 21'h0A9DD},
        '{21'h0A9E0, 21'h0A9FF}, '{21'h0AA37, 21'h0AA3F}, '{21'h0AA4E, 21'h0AA4F},
        '{21'h0AA5A, 21'h0AA5B}, '{21'h0AA7C, 21'h0AA7F}, '{21'h0AAC3, 21'h0AADA},
        '{21'h0AAF7, 21'h0AB00}, '{21'h0AB07, 21'h0AB08}, '{21'h0AB0F, 21'h0AB10},
        '{21'h0AB17, 21'h0AB1F}, '{21'h0AB27, 21'h0AB27}, '{21'h0AB2F, 21'h0ABBF},
        '{21'h0ABEE, 21'h0ABEF}, '{21'h0ABFA, 21'h0ABFF}, '{21'h0D7A4, 21'h0D7AF},
        '{21'h0D7C7, 21'h0D7CA}, '{21'h0D7FC, 21'h0DFFF}, '{21'h0FA6E, 21'h0FA6F},
        '{21'h0FADA, 21'h0FAFF}, '{21'h0FB07, 21'h0FB12}, '{21'h0FB18, 21'h0FB1C},
        '{21'h0FB37, 21'h0FB37}, '{21'h0FB3D, 21'h0FB3D}, '{21'h0FB3F, 21'h0FB3F},
        '{21'h0FB42, 21'h0FB42}, '{21'h0FB45, 21'h0FB45}, '{21'h0FBC2, 21'h0FBD2},
        '{21'h0FD40, 21'h0FD4F}, '{21'h0FD90, 21'h0FD91}, '{21'h0FDC8, 21'h0FDEF},
        '{21'h0FDFE, 21'h0FE0F}, '{21'h0FE1A, 21'h0FE1F}, '{21'h0FE27, 21'h0FE2F},
        '{21'h0FE53, 21'h0FE53}, '{21'h0FE67, 21'h0FE67}, '{21'h0FE6C, 21'h0FE6F},
        '{21'h0FE75, 21'h0FE75}, '{21'h0FEFD, 21'h0FEFF}, '{21'h0FF00, 21'h0FF00},
        '{21'h0FFA0, 21'h0FFA0}, '{21'h0FFBF, 21'h0FFC1}, '{21'h0FFC8, 21'h0FFC9},
        '{21'h0FFD0, 21'h0FFD1}, '{21'h0FFD8, 21'h0FFD9}, '{21'h0FFDD, 21'h0FFDF},
        '{21'h0FFE7, 21'h0FFE7}, '{21'h0FFEF, 21'h0FFFB}, '{21'h0FFFE, 21'h0FFFF},
        '{21'h1000C, 21'h1000C}, '{21'h10027, 21'h10027}, '{21'h1003B, 21'h1003B},
        '{21'h1003E, 21'h1003E}, '{21'h1004E, 21'h1004F}, '{21'h1005E, 21'h1007F},
        '{21'h100FB, 21'h100FF}, '{21'h10103, 21'h10106}, '{21'h10134, 21'h10136},
        '{21'h1018B, 21'h1018F}, '{21'h1019C, 21'h101CF}, '{21'h101FE, 21'h1027F},
        '{21'h1029D, 21'h1029F}, '{21'h102D1, 21'h102FF}, '{21'h1031F, 21'h1031F},
        '{21'h10324, 21'h1032F}, '{21'h1034B, 21'h1037F}, '{21'h1039E, 21'h1039E},
        '{21'h103C4, 21'h103C7}, '{21'h103D6, 21'h103FF}, '{21'h1049E, 21'h1049F},
        '{21'h104AA, 21'h107FF}, '{21'h10806, 21'h10807}, '{21'h10809, 21'h10809},
        '{21'h10836, 21'h10836}, '{21'h10839, 21'h1083B}, '{21'h1083D, 21'h1083E},
        '{21'h10856, 21'h10856}, '{21'h10860, 21'h108FF}, '{21'h1091C, 21'h1091E},
        '{21'h1093A, 21'h1093E}, '{21'h10940, 21'h1097F}, '{21'h109B8, 21'h109BD},
        '{21'h109C0, 21'h109FF}, '{21'h10A04, 21'h10A04}, '{21'h10A07, 21'h10A0B},
        '{21'h10A14, 21'h10A14}, '{21'h10A18, 21'h10A18}, '{21'h10A34, 21'h10A37},
        '{21'h10A3B, 21'h10A3E}, '{21'h10A48, 21'h10A4F}, '{21'h10A59, 21'h10A5F},
        '{21'h10A80, 21'h10AFF}, '{21'h10B36, 21'h10B38}, '{21'h10B56, 21'h10B57},
        '{21'h10B73, 21'h10B77}, '{21'h10B80, 21'h10BFF}, '{21'h10C49, 21'h10E5F},
        '{21'h10E7F, 21'h10FFF}, '{21'h1104E, 21'h11051}, '{21'h11070, 21'h1107F},
        '{21'h110BD, 21'h110BD}, '{21'h110C2, 21'h110CF}, '{21'h110E9, 21'h110EF},
        '{21'h110FA, 21'h110FF}, '{21'h11135, 21'h11135}, '{21'h11144, 21'h1117F},
        '{21'h111C9, 21'h111CF}, '{21'h111DA, 21'h1167F}, '{21'h116B8, 21'h116BF},
        '{21'h116CA, 21'h11FFF}, '{21'h1236F, 21'h123FF}, '{21'h12463, 21'h1246F},
        '{21'h12474, 21'h12FFF}, '{21'h1342F, 21'h167FF}, '{21'h16A39, 21'h16EFF},
        '{21'h16F45, 21'h16F4F}, '{21'h16F7F, 21'h16F8E}, '{21'h16FA0, 21'h1AFFF},
        '{21'h1B002, 21'h1CFFF}, '{21'h1D0F6, 21'h1D0FF}, '{21'h1D127, 21'h1D128},
        '{21'h1D173, 21'h1D17A}, '{21'h1D1DE, 21'h1D1FF}, '{21'h1D246, 21'h1D2FF},
        '{21'h1D357, 21'h1D35F}, '{21'h1D372, 21'h1D3FF}, '{21'h1D455, 21'h1D455},
        '{21'h1D49D, 21'h1D49D}, '{21'h1D4A0, 21'h1D4A1}, '{21'h1D4A3, 21'h1D4A4},
        '{21'h1D4A7, 21'h1D4A8}, '{21'h1D4AD, 21'h1D4AD}, '{21'h1D4BA, 21'h1D4BA},
        '{21'h1D4BC, 21'h1D4BC}, '{21'h1D4C4, 21'h1D4C4}, '{21'h1D506, 21'h1D506},
        '{21'h1D50B, 21'h1D50C}, '{21'h1D515, 21'h1D515}, '{21'h1D51D, 21'h1D51D},
        '{21'h1D53A, 21'h1D53A}, '{21'h1D53F, 21'h1D53F}, '{21'h1D545, 21'h1D545},
        '{21'h1D547, 21'h1D549}, '{21'h1D551, 21'h1D551}, '{21'h1D6A6, 21'h1D6A7},
        '{21'h1D7CC, 21'h1D7CD}, '{21'h1D800, 21'h1EDFF}, '{21'h1EE04, 21'h1EE04},
        '{21'h1EE20, 21'h1EE20}, '{21'h1EE23, 21'h1EE23}, '{21'h1EE25, 21'h1EE26},
        '{21'h1EE28, 21'h1EE28}, '{21'h1EE33, 21'h1EE33}, '{21'h1EE38, 21'h1EE38},
        '{21'h1EE3A, 21'h1EE3A}, '{21'h1EE3C, 21'h1EE41}, '{21'h1EE43, 21'h1EE46},
        '{21'h1EE48, 21'h1EE48}, '{21'h1EE4A, 21'h1EE4A}, '{21'h1EE4C, 21'h1EE4C},
        '{21'h1EE50, 21'h1EE50}, '{21'h1EE53, 21'h1EE53}, '{21'h1EE55, 21'h1EE56},
        '{21'h1EE58, 21'h1EE58}, '{21'h1EE5A, 21'h1EE5A}, '{21'h1EE5C, 21'h1EE5C},
        '{21'h1EE5E, 21'h1EE5E}, '{21'h1EE60, 21'h1EE60}, '{21'h1EE63, 21'h1EE63},
        '{21'h1EE65, 21'h1EE66}, '{21'h1EE6B, 21'h1EE6B}, '{21'h1EE73, 21'h1EE73},
        '{21'h1EE78, 21'h1EE78}, '{21'h1EE7D, 21'h1EE7D}, '{21'h1EE7F, 21'h1EE7F},
        '{21'h1EE8A, 21'h1EE8A}, '{21'h1EE9C, 21'h1EEA0}, '{21'h1EEA4, 21'h1EEA4},
        '{21'h1EEAA, 21'h1EEAA}, '{21'h1EEBC, 21'h1EEEF}, '{21'h1EEF2, 21'h1EFFF},
        '{21'h1F02C, 21'h1F02F}, '{21'h1F094, 21'h1F09F}, '{21'h1F0AF, 21'h1F0B0},
        '{21'h1F0BF, 21'h1F0C0}, '{21'h1F0D0, 21'h1F0D0}, '{21'h1F0E0, 21'h1F0FF},
        '{21'h1F10B, 21'h1F10F}, '{21'h1F12F, 21'h1F12F}, '{21'h1F16C, 21'h1F16F},
        '{21'h1F19B, 21'h1F1E5}, '{21'h1F203, 21'h1F20F}, '{21'h1F23B, 21'h1F23F},
        '{21'h1F249, 21'h1F24F}, '{21'h1F252, 21'h1F2FF}, '{21'h1F321, 21'h1F32F},
        '{21'h1F336, 21'h1F336}, '{21'h1F37D, 21'h1F37F}, '{21'h1F394, 21'h1F39F},
        '{21'h1F3C5, 21'h1F3C5}, '{21'h1F3CB, 21'h1F3DF}, '{21'h1F3F1, 21'h1F3FF},
        '{21'h1F43F, 21'h1F43F}, '{21'h1F441, 21'h1F441}, '{21'h1F4F8, 21'h1F4F8},
        '{21'h1F4FD, 21'h1F4FF}, '{21'h1F53E, 21'h1F53F}, '{21'h1F544, 21'h1F54F},
        '{21'h1F568, 21'h1F5FA}, '{21'h1F641, 21'h1F644}, '{21'h1F650, 21'h1F67F},
        '{21'h1F6C6, 21'h1F6FF}, '{21'h1F774, 21'h1FFFF}, '{21'h2A6D7, 21'h2A6FF},
        '{21'h2B735, 21'h2B73F}, '{21'h2B81E, 21'h2F7FF}, '{21'h2FA1E, 21'h0F0000},
        '{21'h0FFFFE, 21'h0FFFFF}, '{21'h10FFFE, 21'h10FFFF}
    };

endpackage

### rtl/core/upc_if.sv
// Channel interfaces of the classifier: code point in, printable flag out.
// Depends on upc_pkg for the code point type.
`timescale 1ns / 1ps

interface upc_cp_if;
    logic          valid;
    logic          ready;
    upc_pkg::t_cp  code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

interface upc_res_if;
    logic valid;
    logic ready;
    logic printable;

    modport source (output valid, output printable, input ready);
    modport sink   (input valid, input printable, output ready);
endinterface

### rtl/core/unicode_printable_classifier.sv
// Top level of the Unicode printable classifier: a chain of upc_cell stages.
// Depends on upc_pkg, upc_cp_if, upc_res_if and upc_cell.
`timescale 1ns / 1ps

// Classifies one 21-bit code point per cycle as printable or not, while no result
// waits at the output. Each code point walks a chain of cells; every cell checks it
// against up to PER_CELL ranges of the non-printable table (the last cell may have
// fewer), and a new word is taken every cycle unless stalled. The whole chain stalls
// together while a finished result waits at the output; the last cell's register
// is the output register. Values above 0x10FFFF match no range and are printable.
module unicode_printable_classifier #(
    parameter int NUM_RANGES = 548,
    parameter int PER_CELL   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    upc_cp_if.sink           i_cp,
    upc_res_if.source        o_res
);

    localparam int SEARCH_N  = (NUM_RANGES < upc_pkg::ROM_ENTRIES) ?
                               NUM_RANGES : upc_pkg::ROM_ENTRIES;
    localparam int NUM_CELLS = (SEARCH_N + PER_CELL - 1) / PER_CELL;

    upc_pkg::t_cell_word chain [NUM_CELLS+1];
    logic                advance;

    // Stall the whole chain while the output word waits
    assign advance    = !chain[NUM_CELLS].valid || o_res.ready;
    assign i_cp.ready = advance;

    assign chain[0] = '{valid: i_cp.valid, code_point: i_cp.code_point, hit: 1'b0};

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        upc_cell #(
            .BASE     (c * PER_CELL),
            .PER_CELL (PER_CELL),
            .SEARCH_N (SEARCH_N)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_word    (chain[c]),
            .o_word    (chain[c+1])
        );
    end

    // Drive the result word
    assign o_res.valid     = chain[NUM_CELLS].valid;
    assign o_res.printable = !chain[NUM_CELLS].hit;

endmodule

### rtl/core/upc_cell.sv
// One cell of the classifier chain: checks the passing code point against a fixed
// slice of the range table and hands the word on. Depends on upc_pkg.
`timescale 1ns / 1ps

module upc_cell #(
    parameter int BASE     = 0,
    parameter int PER_CELL = 16,
    parameter int SEARCH_N = 548
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  upc_pkg::t_cell_word i_word,
    output upc_pkg::t_cell_word o_word
);

    logic [PER_CELL-1:0] hit;
    logic                r_valid;
    upc_pkg::t_cp        r_cp;
    logic                r_hit;
    logic                n_hit;

    // Compare against each range of this slice
    for (genvar j = 0; j < PER_CELL; j++) begin : g_cmp
        if (BASE + j < SEARCH_N) begin : g_on
            assign hit[j] = (i_word.code_point >= upc_pkg::NP_ROM[BASE+j].first) &&
                            (i_word.code_point <= upc_pkg::NP_ROM[BASE+j].last);
        end else begin : g_off
            assign hit[j] = 1'b0;
        end
    end

    assign n_hit = i_word.hit | (|hit);

    // Clear the valid flag under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_word.valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_cp  <= i_word.code_point;
            r_hit <= n_hit;
        end
    end

    assign o_word = '{valid: r_valid, code_point: r_cp, hit: r_hit};

endmodule

### dv/upc_scoreboard.sv
// Checker for the Unicode printable classifier: watches both channels, predicts
// the printable flag of every accepted code point and compares it in order.
// Depends on upc_pkg, upc_cp_if and upc_res_if.
`timescale 1ns / 1ps

module upc_scoreboard #(
    parameter int NUM_RANGES = 548
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    upc_cp_if     i_cp,
    upc_res_if    i_res,
    output int    o_fail_count,
    output int    o_pending
);

    logic exp_printable_q [$];

    // Binary search over the sorted non-printable ranges
    function automatic logic classify_printable(upc_pkg::t_cp cp);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = (NUM_RANGES < upc_pkg::ROM_ENTRIES) ? NUM_RANGES : upc_pkg::ROM_ENTRIES;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (cp < upc_pkg::NP_ROM[mid].first)
                hi = mid;
            else if (cp > upc_pkg::NP_ROM[mid].last)
                lo = mid + 1;
            else
                return 1'b0;
        end
        return 1'b1;
    endfunction

    assign o_pending = exp_printable_q.size();

    // Queue a prediction per accepted word; check each result word against the oldest
    always @(posedge i_clk) begin
        logic exp_flag;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_cp.valid && i_cp.ready)
                exp_printable_q.push_back(classify_printable(i_cp.code_point));
            if (i_res.valid && i_res.ready) begin
                if (exp_printable_q.size() == 0) begin
                    $display("%0t: unexpected result word, printable=%0b",
                             $time, i_res.printable);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_flag = exp_printable_q.pop_front();
                    if (i_res.printable !== exp_flag) begin
                        $display("%0t: printable mismatch, expected %0b actual %0b",
                                 $time, exp_flag, i_res.printable);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### dv/tb_unicode_printable_classifier.sv
// Top of the classifier testbench: clock, reset, code point stimulus with bursts
// and gaps, result back-pressure and the verdict. Depends on upc_pkg, the
// channel interfaces, unicode_printable_classifier and upc_scoreboard.
`timescale 1ns / 1ps

module tb_unicode_printable_classifier;

    localparam int RANDOM_WORDS = 1030;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   burst_left;
    int   stall_mode;
    int   stall_cycles;

    upc_cp_if  cp_if ();
    upc_res_if res_if ();

    unicode_printable_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cp    (cp_if),
        .o_res   (res_if)
    );

    upc_scoreboard checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cp         (cp_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hold the run within a generous bound
    initial begin
        #3ms;
        $display("tb_unicode_printable_classifier failed");
        $finish;
    end

    // Receiver: switch between always-ready, light and heavy stall phases
    initial begin
        res_if.ready = 1'b0;
        stall_mode   = 0;
        stall_cycles = 0;
    end

    always @(posedge i_clk) begin
        if (stall_cycles == 0) begin
            stall_mode   <= $urandom_range(0, 2);
            stall_cycles <= $urandom_range(20, 200);
        end else begin
            stall_cycles <= stall_cycles - 1;
        end
        case (stall_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= ($urandom_range(0, 9) < 7);
            default: res_if.ready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    // Present one word, with a random gap whenever a burst runs out
    task automatic send_code_point(upc_pkg::t_cp cp);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                cp_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cp_if.valid      <= 1'b1;
        cp_if.code_point <= cp;
        @(posedge i_clk);
        while (!cp_if.ready) @(posedge i_clk);
    endtask

    // Pick a code point at or beside a range edge, or anywhere
    function automatic upc_pkg::t_cp pick_code_point();
        int            idx;
        upc_pkg::t_cp  edge_cp;
        idx = $urandom_range(0, upc_pkg::ROM_ENTRIES - 1);
        case ($urandom_range(0, 7))
            0: edge_cp = upc_pkg::NP_ROM[idx].first - 21'd1;
            1: edge_cp = upc_pkg::NP_ROM[idx].first;
            2: edge_cp = upc_pkg::NP_ROM[idx].last;
            3: edge_cp = upc_pkg::NP_ROM[idx].last + 21'd1;
            4: edge_cp = 21'($urandom_range(0, 16'hFFFF));
            5: edge_cp = 21'($urandom_range(0, 21'h10FFFF));
            default: edge_cp = 21'($urandom());
        endcase
        return edge_cp;
    endfunction

    initial begin
        upc_pkg::t_cp directed_cps [$];
        int           wait_cycles;
        directed_cps = '{21'h000000, 21'h00001F, 21'h000020, 21'h000041, 21'h00007E,
                         21'h00007F, 21'h00009F, 21'h0000A0, 21'h00034F, 21'h000350,
                         21'h02FA1D, 21'h02FA1E, 21'h0F0000, 21'h0F0001, 21'h0FFFFE,
                         21'h10FFFD, 21'h10FFFE, 21'h10FFFF, 21'h110000, 21'h1FFFFF,
                         21'h155555, 21'h0AAAAA};
        i_rst_n          <= 1'b0;
        cp_if.valid      <= 1'b0;
        cp_if.code_point <= '0;
        burst_left = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, table ends and values above the Unicode range
        foreach (directed_cps[i]) send_code_point(directed_cps[i]);
        for (int n = 0; n < RANDOM_WORDS; n++) send_code_point(pick_code_point());
        cp_if.valid <= 1'b0;

        // Drain, then let the pipeline settle
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (60) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_unicode_printable_classifier passed");
        else
            $display("tb_unicode_printable_classifier failed");
        $finish;
    end

endmodule
